// ===== sv/numeric_string_nan_classifier_core_defines.svh =====
// Assertion macros used by the checker file of the NaN classifier.
`ifndef NUMERIC_STRING_NAN_CLASSIFIER_CORE_DEFINES_SVH
`define NUMERIC_STRING_NAN_CLASSIFIER_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define NSNC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define NSNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/nsnc_pkg.sv =====
// Types, codes and byte classification helpers for the NaN classifier.
package nsnc_pkg;

   // value kind codes
   localparam logic [2:0] KIND_INTEGER      = 3'd0;
   localparam logic [2:0] KIND_FLOAT        = 3'd1;
   localparam logic [2:0] KIND_STRING       = 3'd2;
   localparam logic [2:0] KIND_BOXED_STRING = 3'd3;
   localparam logic [2:0] KIND_BOOLEAN      = 3'd4;

   // format version that turns undefined and boolean into NaN
   localparam logic [7:0] VERSION_NAN = 8'd7;

   // register indexes
   localparam logic REG_FORMAT_VERSION = 1'b0;

   // characters of interest
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   // saturating character counter
   localparam logic [1:0] POS_MAX = 2'd3;

   // one input transaction
   typedef struct packed {
      logic [2:0] value_kind;
      logic       is_defined;
      logic       string_empty;
      logic [7:0] char_byte;
      logic       is_last;
   } item_type;

   // verdict of one processed transaction
   typedef struct packed {
      logic has_result;
      logic is_nan;
   } verdict_type;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) ||
             ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CHAR_MINUS) || (c == CHAR_PLUS);
   endfunction

endpackage

// ===== sv/numeric_string_nan_classifier_core.sv =====
// A transaction accepted into the input register gives its result from the result register.
// Throughput: one transaction per cycle unless a stalled result holds the input register; the
//   input register feeds the scan logic and the result register in a single step.
// A character that ends no value advances the scan state and makes no result.
// Reset (synchronous, active high) clears the scan state, both registers'
//   valid flags and the format version.
module numeric_string_nan_classifier_core
   import nsnc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic [4:0]  req_tuser,   // [2:0] value_kind, [3] is_defined, [4] string_empty
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] is_nan, [7:1] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff, in_item_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_nan_ff, rsp_nan_in;
   logic [7:0]  format_version;
   verdict_type verdict;
   logic        step;

   nsnc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .format_version (format_version)
   );

   nsnc_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (in_item_ff),
      .format_version (format_version),
      .verdict        (verdict)
   );

   // advance the held transaction unless its result would overwrite a stalled one
   assign step = in_valid_ff &&
                 (!verdict.has_result || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in  = '{value_kind:   req_tuser[2:0],
                         is_defined:   req_tuser[3],
                         string_empty: req_tuser[4],
                         char_byte:    req_tdata,
                         is_last:      req_tlast};
      end
   end

   // load the result register, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_nan_in   = rsp_nan_ff;
      if (step && verdict.has_result) begin
         rsp_valid_in = 1'b1;
         rsp_nan_in   = verdict.is_nan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff <= in_item_in;
      rsp_nan_ff <= rsp_nan_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_nan_ff};

endmodule

// ===== sv/nsnc_csr.sv =====
// Configuration register block holding the format version.
module nsnc_csr
   import nsnc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [7:0]  format_version
);

   logic [7:0] format_version_ff;
   logic [7:0] format_version_in;
   logic       write_hit;

   // decode a completed write to the version register
   assign write_hit = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr[2] == REG_FORMAT_VERSION);

   always_comb begin
      format_version_in = format_version_ff;
      if (write_hit) begin
         format_version_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_version_ff <= 8'd0;
      end else begin
         format_version_ff <= format_version_in;
      end
   end

   // read back, zero beyond the register list
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_FORMAT_VERSION) begin
         csr_prdata = {24'd0, format_version_ff};
      end
   end

   assign csr_pready     = 1'b1;
   assign format_version = format_version_ff;

endmodule

// ===== sv/nsnc_classify.sv =====
// String scan state and per-transaction NaN verdict.
module nsnc_classify
   import nsnc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   input  logic [7:0]  format_version,
   output verdict_type verdict
);

   logic [1:0] char_position_ff, char_position_in;
   logic [7:0] first_char_ff, first_char_in;
   logic       hex_prefix_seen_ff, hex_prefix_seen_in;
   logic       hex_bad_ff, hex_bad_in;
   logic       dot_seen_ff, dot_seen_in;
   logic       exponent_pending_ff, exponent_pending_in;
   logic       decimal_nan_ff, decimal_nan_in;

   // values after taking the current character
   logic [1:0] t_pos;
   logic [7:0] t_first;
   logic       t_hex_prefix, t_hex_bad, t_dot, t_exp, t_dec_nan;
   logic       is_str, keep_scan;
   logic [7:0] c;

   assign c = item.char_byte;

   // take one character into the scan state
   always_comb begin
      t_pos        = (char_position_ff == POS_MAX) ? POS_MAX : char_position_ff + 2'd1;
      t_first      = first_char_ff;
      t_hex_prefix = hex_prefix_seen_ff;
      t_hex_bad    = hex_bad_ff;
      t_dot        = dot_seen_ff;
      t_exp        = exponent_pending_ff;
      t_dec_nan    = decimal_nan_ff;
      if (char_position_ff == 2'd0) begin
         t_first = c;
         if (!((c == CHAR_DOT) || is_sign(c) || is_dec(c))) begin
            t_dec_nan = 1'b1;
         end
      end else begin
         if (char_position_ff == 2'd1) begin
            t_hex_prefix = (first_char_ff == CHAR_ZERO) && (c == CHAR_X);
         end
         if (char_position_ff[1] && !is_hex(c)) begin
            t_hex_bad = 1'b1;
         end
         if (exponent_pending_ff) begin
            t_exp = 1'b0;
            if (!is_sign(c) && !is_dec(c)) begin
               t_dec_nan = 1'b1;
            end
         end else if ((c == CHAR_DOT) && !dot_seen_ff) begin
            t_dot = 1'b1;
         end else if ((c == CHAR_E) && (char_position_ff != 2'd1)) begin
            if ((char_position_ff == 2'd2) && is_sign(first_char_ff)) begin
               t_dec_nan = 1'b1;
            end else begin
               t_exp = 1'b1;
            end
         end else if (!is_dec(c)) begin
            t_dec_nan = 1'b1;
         end
      end
   end

   // verdict of this transaction
   always_comb begin
      is_str    = item.is_defined &&
                  (item.value_kind inside {KIND_STRING, KIND_BOXED_STRING});
      keep_scan = is_str && !item.string_empty && !item.is_last;
      verdict.has_result = !keep_scan;
      if (is_str) begin
         if (item.string_empty) begin
            verdict.is_nan = 1'b1;
         end else if (char_position_ff[1] && t_hex_prefix) begin
            verdict.is_nan = t_hex_bad;
         end else begin
            verdict.is_nan = t_dec_nan ||
               !(is_sign(c) || (c == CHAR_E) || (c == CHAR_DOT) || is_dec(c));
         end
      end else if (item.is_defined &&
                   (item.value_kind inside {KIND_INTEGER, KIND_FLOAT})) begin
         verdict.is_nan = 1'b0;
      end else if (item.is_defined && (item.value_kind != KIND_BOOLEAN)) begin
         verdict.is_nan = 1'b1;
      end else begin
         verdict.is_nan = (format_version == VERSION_NAN);
      end
   end

   // advance the scan or clear it at the end of a value
   always_comb begin
      char_position_in    = char_position_ff;
      first_char_in       = first_char_ff;
      hex_prefix_seen_in  = hex_prefix_seen_ff;
      hex_bad_in          = hex_bad_ff;
      dot_seen_in         = dot_seen_ff;
      exponent_pending_in = exponent_pending_ff;
      decimal_nan_in      = decimal_nan_ff;
      if (step) begin
         if (keep_scan) begin
            char_position_in    = t_pos;
            first_char_in       = t_first;
            hex_prefix_seen_in  = t_hex_prefix;
            hex_bad_in          = t_hex_bad;
            dot_seen_in         = t_dot;
            exponent_pending_in = t_exp;
            decimal_nan_in      = t_dec_nan;
         end else begin
            char_position_in    = 2'd0;
            first_char_in       = 8'd0;
            hex_prefix_seen_in  = 1'b0;
            hex_bad_in          = 1'b0;
            dot_seen_in         = 1'b0;
            exponent_pending_in = 1'b0;
            decimal_nan_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff    <= 2'd0;
         first_char_ff       <= 8'd0;
         hex_prefix_seen_ff  <= 1'b0;
         hex_bad_ff          <= 1'b0;
         dot_seen_ff         <= 1'b0;
         exponent_pending_ff <= 1'b0;
         decimal_nan_ff      <= 1'b0;
      end else begin
         char_position_ff    <= char_position_in;
         first_char_ff       <= first_char_in;
         hex_prefix_seen_ff  <= hex_prefix_seen_in;
         hex_bad_ff          <= hex_bad_in;
         dot_seen_ff         <= dot_seen_in;
         exponent_pending_ff <= exponent_pending_in;
         decimal_nan_ff      <= decimal_nan_in;
      end
   end

endmodule

// ===== sv/nsnc_checker.sv =====
// Port-level checker for the NaN classifier, bound to the top level.
`include "numeric_string_nan_classifier_core_defines.svh"

module nsnc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a stalled result stays offered and unchanged
   `NSNC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // padding bits of the result stay zero
   `NSNC_ASSERT_SAME(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:1] == 7'd0, "result padding not zero")

   // no result is offered right after reset
   `NSNC_ASSERT_SAME(a_rsp_reset, clock, reset, $past(reset), !rsp_tvalid, "result valid after reset")

endmodule

bind numeric_string_nan_classifier_core nsnc_checker u_nsnc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the numeric string NaN classifier core.
module tb_top;
   import nsnc_pkg::*;

   localparam logic [2:0] KIND_OTHER          = 3'd5;
   localparam logic [2:0] KIND_SPARE_A        = 3'd6;
   localparam logic [2:0] KIND_SPARE_B        = 3'd7;
   localparam logic [2:0] FORMAT_VERSION_ADDR = {REG_FORMAT_VERSION, 2'b00};
   localparam int         LONG_HOLD           = 300;

   // one value transaction as the sender sees it
   typedef struct packed {
      logic [2:0] kind;
      logic       is_def;
      logic       is_empty;
      logic [7:0] ch;
      logic       is_last;
   } scr_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] char_byte
   logic [4:0]  req_tuser = 5'd0;   // [2:0] value_kind, [3] is_defined, [4] string_empty
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [0] is_nan, [7:1] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // stimulus and scoreboard storage
   scr_item_type value_feed_q[$];
   logic         pending_nan_q[$];
   logic [7:0]   text_buf[$];
   scr_item_type offer_item = '0;
   int           fail_count = 0;

   // idling control shared with the driver and the monitor
   bit          tx_idle_en = 1'b1;
   bit          rx_idle_en = 1'b1;
   int          tx_gap = 0;
   int          rx_stall = 0;
   int          rx_hold = 0;
   int          hold_req_cnt = 0;
   int          hold_done_cnt = 0;

   // predictor state
   logic [7:0]  fmt_version = 8'd0;
   logic [1:0]  scan_pos = 2'd0;
   logic [7:0]  lead_char = 8'd0;
   logic        hex_prefix = 1'b0;
   logic        hex_fault = 1'b0;
   logic        dot_found = 1'b0;
   logic        exp_wait = 1'b0;
   logic        dec_fault = 1'b0;

   numeric_string_nan_classifier_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // byte classes used by the scan
   function automatic bit is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic bit is_hex_digit(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_F)) ||
             ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
   endfunction

   function automatic bit is_sign_char(input logic [7:0] c);
      return (c == CHAR_MINUS) || (c == CHAR_PLUS);
   endfunction

   function automatic void clear_scan();
      scan_pos   = 2'd0;
      lead_char  = 8'd0;
      hex_prefix = 1'b0;
      hex_fault  = 1'b0;
      dot_found  = 1'b0;
      exp_wait   = 1'b0;
      dec_fault  = 1'b0;
   endfunction

   // advance the string scan by one character
   function automatic void scan_char(input logic [7:0] c);
      if (scan_pos == 2'd0) begin
         lead_char = c;
         if (!(c == CHAR_DOT || is_sign_char(c) || is_digit(c)))
            dec_fault = 1'b1;
      end else begin
         if (scan_pos == 2'd1)
            hex_prefix = (lead_char == CHAR_ZERO) && (c == CHAR_X);
         if (scan_pos >= 2'd2 && !is_hex_digit(c))
            hex_fault = 1'b1;
         if (exp_wait) begin
            exp_wait = 1'b0;
            if (!is_sign_char(c) && !is_digit(c))
               dec_fault = 1'b1;
         end else if (c == CHAR_DOT && !dot_found) begin
            dot_found = 1'b1;
         end else if (c == CHAR_E && scan_pos != 2'd1) begin
            // an exponent two places behind a leading sign is rejected
            if (scan_pos == 2'd2 && is_sign_char(lead_char))
               dec_fault = 1'b1;
            else
               exp_wait = 1'b1;
         end else if (!is_digit(c)) begin
            dec_fault = 1'b1;
         end
      end
      if (scan_pos != POS_MAX)
         scan_pos = scan_pos + 2'd1;
   endfunction

   // work out the verdict of one accepted transaction, if it makes one
   function automatic void classify_value(input scr_item_type it);
      logic [1:0] pos_before;
      logic       nan;
      if (it.is_def && (it.kind == KIND_STRING || it.kind == KIND_BOXED_STRING)) begin
         if (it.is_empty) begin
            clear_scan();
            pending_nan_q.push_back(1'b1);
            return;
         end
         pos_before = scan_pos;
         scan_char(it.ch);
         if (!it.is_last)
            return;
         if (!(is_sign_char(it.ch) || it.ch == CHAR_E || it.ch == CHAR_DOT || is_digit(it.ch)))
            dec_fault = 1'b1;
         nan = (pos_before >= 2'd2 && hex_prefix) ? hex_fault : dec_fault;
      end else if (it.is_def && (it.kind == KIND_INTEGER || it.kind == KIND_FLOAT)) begin
         nan = 1'b0;
      end else if (it.is_def && it.kind != KIND_BOOLEAN) begin
         nan = 1'b1;
      end else begin
         nan = (fmt_version == VERSION_NAN);
      end
      clear_scan();
      pending_nan_q.push_back(nan);
   endfunction

   // feed the block from the pending queue, one gap draw per transaction
   always @(posedge clock) begin : req_driver
      bit show;
      if (reset) begin
         tx_gap = 0;
         req_tvalid <= 1'b0;
      end else begin
         show = req_tvalid;
         if (req_tvalid && req_tready) begin
            classify_value(offer_item);
            show = 1'b0;
            tx_gap = tx_idle_en ? $urandom_range(0, 9) : 0;
         end
         if (!show) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (value_feed_q.size() != 0) begin
               offer_item = value_feed_q.pop_front();
               show = 1'b1;
            end
         end
         req_tvalid <= show;
         req_tdata  <= offer_item.ch;
         req_tuser  <= {offer_item.is_empty, offer_item.is_def, offer_item.kind};
         req_tlast  <= offer_item.is_last;
      end
   end

   // check each result against the oldest verdict and pace rsp_tready
   always @(posedge clock) begin : rsp_monitor
      logic want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_nan_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual tdata %02h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_nan_q.pop_front();
               if (rsp_tdata !== {7'd0, want}) begin
                  $display("%0t: is_nan mismatch: expected tdata %02h, actual tdata %02h",
                           $time, {7'd0, want}, rsp_tdata);
                  fail_count++;
               end
            end
            rx_stall = rx_idle_en ? $urandom_range(0, 9) : 0;
         end
         if (hold_req_cnt != hold_done_cnt) begin
            rx_hold = LONG_HOLD;
            hold_done_cnt++;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // single register write: setup cycle, then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == FORMAT_VERSION_ADDR)
         fmt_version = data[7:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // hold until the block has drained, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      while (value_feed_q.size() != 0 || req_tvalid || pending_nan_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void queue_value(input logic [2:0] kind, input logic is_def);
      scr_item_type it;
      it.kind     = kind;
      it.is_def   = is_def;
      it.is_empty = 1'($urandom_range(0, 1));
      it.ch       = 8'($urandom_range(0, 255));
      it.is_last  = 1'($urandom_range(0, 1));
      value_feed_q.push_back(it);
   endfunction

   function automatic void queue_empty_string(input logic [2:0] kind);
      scr_item_type it;
      it.kind     = kind;
      it.is_def   = 1'b1;
      it.is_empty = 1'b1;
      it.ch       = 8'($urandom_range(0, 255));
      it.is_last  = 1'($urandom_range(0, 1));
      value_feed_q.push_back(it);
   endfunction

   // move the text buffer out as characters; an open string gets no end mark
   function automatic void queue_text(input logic [2:0] kind, input bit closed);
      scr_item_type it;
      foreach (text_buf[i]) begin
         it.kind     = kind;
         it.is_def   = 1'b1;
         it.is_empty = 1'b0;
         it.ch       = text_buf[i];
         it.is_last  = closed && (i == text_buf.size() - 1);
         value_feed_q.push_back(it);
      end
      text_buf.delete();
   endfunction

   function automatic void queue_literal(input logic [2:0] kind, input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
      queue_text(kind, 1'b1);
   endfunction

   // a byte likely to hit one of the scan rules
   function automatic logic [7:0] odd_char();
      case ($urandom_range(0, 11))
         0:       return 8'(CHAR_ZERO + $urandom_range(0, 9));
         1:       return CHAR_DOT;
         2:       return CHAR_E;
         3:       return CHAR_X;
         4:       return CHAR_PLUS;
         5:       return CHAR_MINUS;
         6:       return 8'(CHAR_LO_A + $urandom_range(0, 5));
         7:       return 8'(CHAR_UP_A + $urandom_range(0, 5));
         8:       return 8'h45;
         9:       return 8'h00;
         10:      return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_digits(input int n);
      for (int i = 0; i < n; i++)
         text_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
   endfunction

   function automatic void add_sign();
      case ($urandom_range(0, 3))
         0:       text_buf.push_back(CHAR_MINUS);
         1:       text_buf.push_back(CHAR_PLUS);
         default: ;
      endcase
   endfunction

   // sign, mantissa with optional dot, optional exponent
   function automatic void build_decimal();
      add_sign();
      if ($urandom_range(0, 5) == 0) begin
         text_buf.push_back(CHAR_DOT);
         add_digits($urandom_range(1, 2));
      end else begin
         add_digits($urandom_range(1, 3));
         if ($urandom_range(0, 2) == 0) begin
            text_buf.push_back(CHAR_DOT);
            add_digits($urandom_range(0, 2));
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         text_buf.push_back(CHAR_E);
         add_sign();
         add_digits($urandom_range(0, 2));
      end
   endfunction

   function automatic void build_hex();
      int n;
      text_buf.push_back(CHAR_ZERO);
      text_buf.push_back(CHAR_X);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0:       text_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            1:       text_buf.push_back(8'(CHAR_LO_A + $urandom_range(0, 5)));
            default: text_buf.push_back(8'(CHAR_UP_A + $urandom_range(0, 5)));
         endcase
      end
      if (n > 0 && $urandom_range(0, 3) == 0)
         text_buf[$urandom_range(2, text_buf.size() - 1)] = odd_char();
   endfunction

   function automatic void build_text();
      int sel;
      int n;
      text_buf.delete();
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
         build_decimal();
      end else if (sel <= 5) begin
         build_hex();
      end else if (sel <= 7) begin
         build_decimal();
         text_buf[$urandom_range(0, text_buf.size() - 1)] = odd_char();
      end else begin
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++)
            text_buf.push_back(sel == 8 ? odd_char() : 8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic logic [2:0] string_kind();
      return $urandom_range(0, 1) ? KIND_BOXED_STRING : KIND_STRING;
   endfunction

   // mostly whole numeric strings, some cut short, empty or non-string values
   function automatic void random_batch(input int count);
      int made;
      int r;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            build_text();
            made += text_buf.size();
            queue_text(string_kind(), 1'b1);
         end else if (r < 66) begin
            queue_empty_string(string_kind());
            made++;
         end else if (r < 72) begin
            build_text();
            made += text_buf.size();
            queue_text(string_kind(), 1'b0);
         end else begin
            queue_value(3'($urandom_range(0, 7)), $urandom_range(0, 3) != 0);
            made++;
         end
      end
   endfunction

   // run limit
   initial begin
      #5_000_000;
      $display("numeric_string_nan_classifier_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] versions[6];
      versions = '{8'd255, VERSION_NAN, 8'd0, 8'd6, VERSION_NAN, 8'($urandom_range(0, 255))};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed values under the reset format version
      queue_value(KIND_INTEGER, 1'b1);
      queue_value(KIND_FLOAT, 1'b1);
      queue_value(KIND_BOOLEAN, 1'b1);
      queue_value(KIND_OTHER, 1'b1);
      queue_value(KIND_SPARE_B, 1'b1);
      queue_value(KIND_STRING, 1'b0);
      queue_empty_string(KIND_STRING);
      queue_empty_string(KIND_BOXED_STRING);
      queue_literal(KIND_BOXED_STRING, "0xAf");
      queue_literal(KIND_STRING, ".5");
      queue_literal(KIND_STRING, "1e+5");
      // partial string dropped by a non-string value
      text_buf.push_back(CHAR_NINE);
      queue_text(KIND_STRING, 1'b0);
      queue_value(KIND_INTEGER, 1'b1);
      // byte extremes as one-character strings
      text_buf.push_back(8'h00);
      queue_text(KIND_STRING, 1'b1);
      text_buf.push_back(8'hFF);
      queue_text(KIND_BOXED_STRING, 1'b1);
      wait_idle();

      // undefined and boolean values under the NaN format version
      csr_write(FORMAT_VERSION_ADDR, {24'($urandom), VERSION_NAN});
      queue_value(KIND_BOOLEAN, 1'b0);
      queue_value(KIND_INTEGER, 1'b0);
      queue_value(KIND_BOOLEAN, 1'b1);
      queue_value(KIND_SPARE_A, 1'b0);
      wait_idle();

      // random phases, one format version each
      for (int p = 0; p < 6; p++) begin
         csr_write(FORMAT_VERSION_ADDR, {24'($urandom), versions[p]});
         tx_idle_en = (p != 1) && (p != 3);
         rx_idle_en = (p != 3);
         // back-pressure the block while the sender keeps offering
         if (p == 1)
            hold_req_cnt++;
         random_batch(64);
         wait_idle();
         random_batch(64);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_nan_q.size() == 0)
         $display("numeric_string_nan_classifier_core regression: pass");
      else
         $display("numeric_string_nan_classifier_core regression: fail");
      $finish;
   end

endmodule
